// ===== hdl/pat_pkg.sv =====
// Shared types and constants for the prescaled alarm timer register block.
// Used by pat_timer and prescaled_alarm_timer_regs_top; no dependencies.

package pat_pkg;

   // Default sizing handed to the top level parameters
   localparam int NUM_TIMERS_DEF    = 4;
   localparam int PRESCALE_BITS_DEF = 16;

   // Fixed field widths
   localparam int FUNC_W  = 2;
   localparam int TSEL_W  = 2;
   localparam int RIDX_W  = 4;
   localparam int DATA_W  = 32;
   localparam int CNT_W   = 64;
   localparam int IRQ_W   = 4;
   localparam int DIV_W   = 16;

   // Config word bit positions
   localparam int CFG_ENABLE_BIT     = 31;
   localparam int CFG_AUTORELOAD_BIT = 29;
   localparam int CFG_PRESC_LSB      = 13;
   localparam int CFG_ALARM_EN_BIT   = 10;

   // Transaction kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   // Register word offsets within one timer
   localparam logic [RIDX_W-1:0] REG_CONFIG   = 4'd0;
   localparam logic [RIDX_W-1:0] REG_LO       = 4'd1;
   localparam logic [RIDX_W-1:0] REG_HI       = 4'd2;
   localparam logic [RIDX_W-1:0] REG_UPDATE   = 4'd3;
   localparam logic [RIDX_W-1:0] REG_ALARM_LO = 4'd4;
   localparam logic [RIDX_W-1:0] REG_ALARM_HI = 4'd5;
   localparam logic [RIDX_W-1:0] REG_LOAD_LO  = 4'd6;
   localparam logic [RIDX_W-1:0] REG_LOAD_HI  = 4'd7;
   localparam logic [RIDX_W-1:0] REG_LOAD     = 4'd8;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [TSEL_W-1:0] timer_sel;
      logic [RIDX_W-1:0] reg_index;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [IRQ_W-1:0]  irq_pending;
      logic [IRQ_W-1:0]  alarm_fired;
   } rsp_type;

   // Per-timer command for the transaction being processed
   typedef struct packed {
      logic              tick;
      logic              wr;
      logic [RIDX_W-1:0] reg_index;
      logic [DATA_W-1:0] wdata;
   } timer_op_type;

endpackage

// ===== hdl/pat_timer.sv =====
// One prescaled 64-bit alarm timer: config, counter, snapshot, alarm, load value.
// Depends on pat_pkg.

module pat_timer
   import pat_pkg::*;
#(
   parameter int PRESCALE_BITS = PRESCALE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  timer_op_type      op,
   output logic [DATA_W-1:0] rd_data,
   output logic              pend_next,
   output logic              fired
);

   logic [DATA_W-1:0]        ctrl_ff,   ctrl_in;
   logic [CNT_W-1:0]         count_ff,  count_in;
   logic [CNT_W-1:0]         snap_ff,   snap_in;
   logic [CNT_W-1:0]         alarm_ff,  alarm_in;
   logic [CNT_W-1:0]         reload_ff, reload_in;
   logic [DIV_W-1:0]         dc_ff,     dc_in;
   logic                     pend_ff,   pend_in;

   logic [PRESCALE_BITS-1:0] presc;
   logic [DIV_W:0]           div;
   logic [DIV_W-1:0]         dc_wrap;
   logic                     step;
   logic [CNT_W-1:0]         count_inc;
   logic                     hit;

   // Prescale divider and count step
   always_comb begin
      presc     = ctrl_ff[CFG_PRESC_LSB +: PRESCALE_BITS];
      div       = (presc == '0) ? (DIV_W+1)'(2**PRESCALE_BITS) : (DIV_W+1)'(presc);
      dc_wrap   = dc_ff + DIV_W'(1);
      step      = ({1'b0, dc_wrap} >= div) || (dc_wrap == '0);
      count_inc = count_ff + CNT_W'(1);
      hit       = ctrl_ff[CFG_ALARM_EN_BIT] && (count_inc == alarm_ff);
   end

   // Next state for tick or register write
   always_comb begin
      ctrl_in   = ctrl_ff;
      count_in  = count_ff;
      snap_in   = snap_ff;
      alarm_in  = alarm_ff;
      reload_in = reload_ff;
      dc_in     = dc_ff;
      pend_in   = pend_ff;
      fired     = 1'b0;
      if (op.tick && ctrl_ff[CFG_ENABLE_BIT]) begin
         if (!step) begin
            dc_in = dc_wrap;
         end else begin
            dc_in    = '0;
            count_in = count_inc;
            if (hit) begin
               ctrl_in[CFG_ALARM_EN_BIT] = 1'b0;
               pend_in = 1'b1;
               fired   = 1'b1;
               if (ctrl_ff[CFG_AUTORELOAD_BIT]) begin
                  count_in = reload_ff;
               end
            end
         end
      end else if (op.wr) begin
         case (op.reg_index)
            REG_CONFIG: begin
               ctrl_in = op.wdata;
               pend_in = 1'b0;
            end
            REG_UPDATE:   snap_in                    = count_ff;
            REG_ALARM_LO: alarm_in[DATA_W-1:0]       = op.wdata;
            REG_ALARM_HI: alarm_in[CNT_W-1:DATA_W]   = op.wdata;
            REG_LOAD_LO:  reload_in[DATA_W-1:0]      = op.wdata;
            REG_LOAD_HI:  reload_in[CNT_W-1:DATA_W]  = op.wdata;
            REG_LOAD: begin
               count_in = reload_ff;
               dc_in    = '0;
            end
            default: ;
         endcase
      end
      pend_next = pend_in;
   end

   // Register read selection
   always_comb begin
      case (op.reg_index)
         REG_CONFIG:   rd_data = ctrl_ff;
         REG_LO:       rd_data = snap_ff[DATA_W-1:0];
         REG_HI:       rd_data = snap_ff[CNT_W-1:DATA_W];
         REG_ALARM_LO: rd_data = alarm_ff[DATA_W-1:0];
         REG_ALARM_HI: rd_data = alarm_ff[CNT_W-1:DATA_W];
         REG_LOAD_LO:  rd_data = reload_ff[DATA_W-1:0];
         REG_LOAD_HI:  rd_data = reload_ff[CNT_W-1:DATA_W];
         default:      rd_data = '0;
      endcase
   end

   // Hold timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= '0;
         count_ff  <= '0;
         snap_ff   <= '0;
         alarm_ff  <= '0;
         reload_ff <= '0;
         dc_ff     <= '0;
         pend_ff   <= 1'b0;
      end else begin
         ctrl_ff   <= ctrl_in;
         count_ff  <= count_in;
         snap_ff   <= snap_in;
         alarm_ff  <= alarm_in;
         reload_ff <= reload_in;
         dc_ff     <= dc_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

// ===== hdl/prescaled_alarm_timer_regs_top.sv =====
// Top level of the prescaled alarm timer register block.
// Depends on pat_pkg and pat_timer.

// The block takes one transaction per clock cycle while req_stall is low
// (register read, register write, or a tick for all timers) and returns one
// result per transaction: the request waits in the request register, then the
// timer update and read selection land in the result register. The longest
// path is each timer's 64-bit count increment and alarm compare. The result
// register parts the two sides, so a new request is taken while a finished
// result waits to be taken; req_stall rises only when both stages are full
// and rsp_stall is high. Timers beyond index 3 are not addressable, and only
// timers 0 to 3 appear on irq_pending and alarm_fired.

module prescaled_alarm_timer_regs_top
   import pat_pkg::*;
#(
   parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
   parameter int PRESCALE_BITS = PRESCALE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int IRQ_N = (NUM_TIMERS < IRQ_W) ? NUM_TIMERS : IRQ_W;

   logic                    in_valid_ff, in_valid_in;
   req_type                 in_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_ff, out_in;
   logic                    advance;
   logic                    accept;

   timer_op_type            op     [NUM_TIMERS];
   logic [DATA_W-1:0]       rd_t   [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]   pend_vec;
   logic [NUM_TIMERS-1:0]   fired_vec;
   logic [DATA_W-1:0]       rd_sel;

   // Handshake: move a transaction into the result register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   // Timers
   for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
      always_comb begin
         op[t].tick      = advance && (in_ff.func == FUNC_TICK);
         op[t].wr        = advance && (in_ff.func == FUNC_WRITE)
                           && (32'(in_ff.timer_sel) == t);
         op[t].reg_index = in_ff.reg_index;
         op[t].wdata     = in_ff.write_data;
      end

      pat_timer #(
         .PRESCALE_BITS (PRESCALE_BITS)
      ) u_timer (
         .clock     (clock),
         .reset     (reset),
         .op        (op[t]),
         .rd_data   (rd_t[t]),
         .pend_next (pend_vec[t]),
         .fired     (fired_vec[t])
      );
   end

   // Select read data of the addressed timer
   always_comb begin
      rd_sel = '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         if (32'(in_ff.timer_sel) == t) begin
            rd_sel = rd_t[t];
         end
      end
   end

   // Build the result
   always_comb begin
      out_in.read_data   = (in_ff.func == FUNC_READ) ? rd_sel : '0;
      out_in.irq_pending = IRQ_W'(pend_vec[IRQ_N-1:0]);
      out_in.alarm_fired = IRQ_W'(fired_vec[IRQ_N-1:0]);
   end

   // Hold request and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // A fired alarm always leaves its pending line set
   a_fired_pending: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((out_ff.alarm_fired & ~out_ff.irq_pending) == '0))
      else $error("alarm fired without pending");

   // Only reads return data
   a_read_data: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ff.func != FUNC_READ)) |=> (out_ff.read_data == '0))
      else $error("read data on non-read transaction");

   // Alarms fire only on ticks
   a_fire_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ff.func != FUNC_TICK)) |=> (out_ff.alarm_fired == '0))
      else $error("alarm fired outside a tick");

   // Back-pressure only with both stages full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room available");

endmodule

// ===== tb/prescaled_alarm_timer_regs_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for prescaled_alarm_timer_regs_top: random bursts of register
// transactions and ticks, predicted per timer and checked on the result channel.
// Depends on pat_pkg and the block's RTL.

module prescaled_alarm_timer_regs_top_tb;
   import pat_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_OPS = 560;
   localparam int PRESC_W = PRESCALE_BITS_DEF;

   // Transaction kind with no function, and offsets outside the register map
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
   localparam logic [RIDX_W-1:0] REG_UNUSED_LO = 4'd9;
   localparam logic [RIDX_W-1:0] REG_UNUSED_HI = 4'd15;

   // Config word fields
   localparam logic [31:0] CW_ENABLE = 32'd1 << CFG_ENABLE_BIT;
   localparam logic [31:0] CW_AUTORELOAD = 32'd1 << CFG_AUTORELOAD_BIT;
   localparam logic [31:0] CW_ALARM_EN = 32'd1 << CFG_ALARM_EN_BIT;
   localparam logic [31:0] CW_SPARE_BITS = 32'h4000_1BFF;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Timer state as the block should hold it
   logic [31:0]        tmr_ctrl   [NUM_TIMERS_DEF];
   logic [63:0]        tmr_count  [NUM_TIMERS_DEF];
   logic [63:0]        tmr_snap   [NUM_TIMERS_DEF];
   logic [63:0]        tmr_alarm  [NUM_TIMERS_DEF];
   logic [63:0]        tmr_reload [NUM_TIMERS_DEF];
   logic [PRESC_W-1:0] tmr_div    [NUM_TIMERS_DEF];
   logic               tmr_pend   [NUM_TIMERS_DEF];

   req_type bus_ops[$];
   bit      drain_before[$];
   rsp_type timer_rsps_due[$];
   int      rsps_in_flight;
   bit      failed;
   int      cycle_count;

   int burst_left;
   int gap_left;
   int stall_left;
   logic [7:0] stall_pattern;

   prescaled_alarm_timer_regs_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // Apply one transaction to the timer state and return the result it yields
   function automatic rsp_type step_timers(input req_type op);
      rsp_type             r;
      int                  t;
      int                  i;
      logic [31:0]         cw;
      logic [PRESC_W-1:0]  presc;
      logic [PRESC_W:0]    div_len;
      r = '0;
      t = op.timer_sel;
      case (op.func)
         FUNC_READ: begin
            if (t < NUM_TIMERS_DEF) begin
               case (op.reg_index)
                  REG_CONFIG:   r.read_data = tmr_ctrl[t];
                  REG_LO:       r.read_data = tmr_snap[t][31:0];
                  REG_HI:       r.read_data = tmr_snap[t][63:32];
                  REG_ALARM_LO: r.read_data = tmr_alarm[t][31:0];
                  REG_ALARM_HI: r.read_data = tmr_alarm[t][63:32];
                  REG_LOAD_LO:  r.read_data = tmr_reload[t][31:0];
                  REG_LOAD_HI:  r.read_data = tmr_reload[t][63:32];
                  default:      r.read_data = '0;
               endcase
            end
         end
         FUNC_WRITE: begin
            if (t < NUM_TIMERS_DEF) begin
               case (op.reg_index)
                  REG_CONFIG: begin
                     tmr_ctrl[t] = op.write_data;
                     tmr_pend[t] = 1'b0;
                  end
                  REG_UPDATE:   tmr_snap[t] = tmr_count[t];
                  REG_ALARM_LO: tmr_alarm[t][31:0] = op.write_data;
                  REG_ALARM_HI: tmr_alarm[t][63:32] = op.write_data;
                  REG_LOAD_LO:  tmr_reload[t][31:0] = op.write_data;
                  REG_LOAD_HI:  tmr_reload[t][63:32] = op.write_data;
                  REG_LOAD: begin
                     tmr_count[t] = tmr_reload[t];
                     tmr_div[t] = '0;
                  end
                  default: ;
               endcase
            end
         end
         FUNC_TICK: begin
            for (i = 0; i < NUM_TIMERS_DEF; i++) begin
               cw = tmr_ctrl[i];
               if (cw[CFG_ENABLE_BIT]) begin
                  // a zero prescaler divides by the full range
                  presc = cw[CFG_PRESC_LSB +: PRESC_W];
                  div_len = (presc == '0) ? {1'b1, {PRESC_W{1'b0}}} : {1'b0, presc};
                  tmr_div[i] = tmr_div[i] + 1'b1;
                  if (tmr_div[i] == '0 || {1'b0, tmr_div[i]} >= div_len) begin
                     tmr_div[i] = '0;
                     tmr_count[i] = tmr_count[i] + 64'd1;
                     if (cw[CFG_ALARM_EN_BIT] && tmr_count[i] == tmr_alarm[i]) begin
                        tmr_ctrl[i][CFG_ALARM_EN_BIT] = 1'b0;
                        tmr_pend[i] = 1'b1;
                        if (i < IRQ_W)
                           r.alarm_fired[i] = 1'b1;
                        if (cw[CFG_AUTORELOAD_BIT])
                           tmr_count[i] = tmr_reload[i];
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      for (i = 0; i < NUM_TIMERS_DEF && i < IRQ_W; i++)
         r.irq_pending[i] = tmr_pend[i];
      return r;
   endfunction

   task automatic queue_op(input logic [FUNC_W-1:0] f, input int t,
                           input logic [RIDX_W-1:0] ri, input logic [31:0] d,
                           input bit drain);
      req_type op;
      op.func = f;
      op.timer_sel = TSEL_W'(t);
      op.reg_index = ri;
      op.write_data = d;
      bus_ops.push_back(op);
      drain_before.push_back(drain);
   endtask

   task automatic queue_tick();
      queue_op(FUNC_TICK, $urandom_range(0, 3), RIDX_W'($urandom_range(0, 15)), $urandom, 1'b0);
   endtask

   // Sender: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bus_ops.size() == 0) begin
            req_valid <= 1'b0;
         end else if (drain_before[0] && (req_valid || rsps_in_flight != 0)) begin
            // hold off until every outstanding result has been taken
            req_valid <= 1'b0;
         end else begin
            req_payload <= bus_ops.pop_front();
            void'(drain_before.pop_front());
            req_valid <= 1'b1;
            if (burst_left == 0)
               burst_left = $urandom_range(1, 32);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end
   end

   // Receiver: stall on a rotating 8-bit pattern, renewed now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         stall_pattern = '0;
      end else begin
         if (stall_left == 0) begin
            stall_left = $urandom_range(16, 200);
            stall_pattern = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
         end
         stall_left--;
         stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
         rsp_stall <= stall_pattern[0];
      end
   end

   // Monitor: predict each accepted transaction, check each accepted result
   always @(posedge clock) begin : monitor
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < NUM_TIMERS_DEF; i++) begin
            tmr_ctrl[i] = '0;
            tmr_count[i] = '0;
            tmr_snap[i] = '0;
            tmr_alarm[i] = '0;
            tmr_reload[i] = '0;
            tmr_div[i] = '0;
            tmr_pend[i] = 1'b0;
         end
         timer_rsps_due.delete();
         rsps_in_flight <= 0;
      end else begin
         if (req_valid && !req_stall)
            timer_rsps_due.push_back(step_timers(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (timer_rsps_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_payload);
               failed = 1'b1;
            end else begin
               want = timer_rsps_due.pop_front();
               if (rsp_payload.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h, got %h", $time,
                           want.read_data, rsp_payload.read_data);
                  failed = 1'b1;
               end
               if (rsp_payload.irq_pending !== want.irq_pending) begin
                  $display("%0t: irq_pending expected %h, got %h", $time,
                           want.irq_pending, rsp_payload.irq_pending);
                  failed = 1'b1;
               end
               if (rsp_payload.alarm_fired !== want.alarm_fired) begin
                  $display("%0t: alarm_fired expected %h, got %h", $time,
                           want.alarm_fired, rsp_payload.alarm_fired);
                  failed = 1'b1;
               end
            end
         end
         rsps_in_flight <= timer_rsps_due.size();
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("prescaled_alarm_timer_regs_top_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int          t;
      int          n;
      int          steps;
      int          ticks;
      int          presc_len;
      logic [15:0] presc;
      logic [63:0] load;
      logic [31:0] cw;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      failed = 1'b0;
      cycle_count = 0;
      rsps_in_flight = 0;

      // Directed: wrap of the counter onto a zero alarm with auto-reload
      queue_op(FUNC_READ, 0, REG_CONFIG, 32'h0, 1'b0);
      queue_op(FUNC_WRITE, 1, REG_LOAD_LO, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_WRITE, 1, REG_LOAD_HI, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_WRITE, 1, REG_ALARM_LO, 32'h0, 1'b0);
      queue_op(FUNC_WRITE, 1, REG_ALARM_HI, 32'h0, 1'b0);
      queue_op(FUNC_WRITE, 1, REG_CONFIG,
               CW_ENABLE | CW_ALARM_EN | CW_AUTORELOAD | (32'd1 << CFG_PRESC_LSB), 1'b0);
      queue_op(FUNC_WRITE, 1, REG_LOAD, 32'h0, 1'b0);
      queue_op(FUNC_TICK, 0, REG_CONFIG, 32'h0, 1'b0);
      queue_op(FUNC_TICK, 3, REG_UNUSED_HI, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_WRITE, 1, REG_UPDATE, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_READ, 1, REG_LO, 32'h0, 1'b0);
      queue_op(FUNC_READ, 1, REG_HI, 32'h0, 1'b0);
      queue_op(FUNC_READ, 1, REG_CONFIG, 32'h0, 1'b0);
      queue_op(FUNC_READ, 1, REG_ALARM_LO, 32'h0, 1'b0);
      queue_op(FUNC_READ, 1, REG_LOAD_HI, 32'h0, 1'b0);
      queue_op(FUNC_READ, 1, REG_UPDATE, 32'h0, 1'b0);
      queue_op(FUNC_READ, 1, REG_LOAD, 32'h0, 1'b0);
      // unused offsets and the kind with no function
      queue_op(FUNC_READ, 2, REG_UNUSED_HI, 32'h0, 1'b0);
      queue_op(FUNC_WRITE, 3, REG_UNUSED_LO, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_NONE, 3, REG_UNUSED_HI, 32'hFFFF_FFFF, 1'b0);
      // clear pending once the pipeline is empty
      queue_op(FUNC_WRITE, 1, REG_CONFIG, 32'h0, 1'b1);
      queue_op(FUNC_WRITE, 3, REG_CONFIG, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_READ, 3, REG_CONFIG, 32'h0, 1'b0);
      queue_op(FUNC_WRITE, 0, REG_ALARM_HI, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_READ, 0, REG_ALARM_HI, 32'h0, 1'b0);

      // Random: mostly armed alarm scenarios, the rest raw noise
      n = bus_ops.size() + RANDOM_OPS;
      while (bus_ops.size() < n) begin
         if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 8))
               queue_op(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 3),
                        RIDX_W'($urandom_range(0, 15)), $urandom, 1'b0);
         end else begin
            t = $urandom_range(0, 3);
            steps = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: presc = 16'($urandom_range(1, 3));
               7, 8:                presc = 16'($urandom_range(4, 6));
               default:             presc = 16'($urandom);
            endcase
            load = ($urandom_range(0, 4) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3)
                                               : {$urandom, $urandom};
            cw = CW_ENABLE | ({16'h0, presc} << CFG_PRESC_LSB) | ($urandom & CW_SPARE_BITS);
            if ($urandom_range(0, 7) != 0)
               cw = cw | CW_ALARM_EN;
            if ($urandom_range(0, 1) != 0)
               cw = cw | CW_AUTORELOAD;
            queue_op(FUNC_WRITE, t, REG_LOAD_LO, load[31:0], $urandom_range(0, 9) == 0);
            queue_op(FUNC_WRITE, t, REG_LOAD_HI, load[63:32], 1'b0);
            queue_op(FUNC_WRITE, t, REG_ALARM_LO, 32'(load + steps), 1'b0);
            queue_op(FUNC_WRITE, t, REG_ALARM_HI, 32'((load + steps) >> 32), 1'b0);
            queue_op(FUNC_WRITE, t, REG_CONFIG, cw, 1'b0);
            queue_op(FUNC_WRITE, t, REG_LOAD, $urandom, 1'b0);
            presc_len = (presc == 0) ? 65536 : presc;
            ticks = steps * presc_len + $urandom_range(0, 2);
            if (ticks > 40)
               ticks = 40;
            repeat (ticks) begin
               if ($urandom_range(0, 5) == 0)
                  queue_op(FUNC_READ, $urandom_range(0, 3), RIDX_W'($urandom_range(0, 8)),
                           $urandom, 1'b0);
               queue_tick();
            end
            queue_op(FUNC_WRITE, t, REG_UPDATE, $urandom, 1'b0);
            queue_op(FUNC_READ, t, REG_LO, $urandom, 1'b0);
            queue_op(FUNC_READ, t, REG_HI, $urandom, 1'b0);
            queue_op(FUNC_READ, t, REG_CONFIG, $urandom, 1'b0);
            case ($urandom_range(0, 2))
               0: queue_op(FUNC_WRITE, t, REG_CONFIG, 32'h0, 1'b0);
               1: queue_op(FUNC_WRITE, t, REG_CONFIG, cw, 1'b0);
               default: ;
            endcase
         end
      end

      // Prescaler of zero: the divider runs its full range, so a short run of
      // ticks leaves the count where the load put it
      queue_op(FUNC_WRITE, 2, REG_LOAD_LO, 32'h0, 1'b1);
      queue_op(FUNC_WRITE, 2, REG_LOAD_HI, 32'h0, 1'b0);
      queue_op(FUNC_WRITE, 2, REG_ALARM_LO, 32'h1, 1'b0);
      queue_op(FUNC_WRITE, 2, REG_ALARM_HI, 32'h0, 1'b0);
      queue_op(FUNC_WRITE, 2, REG_CONFIG, CW_ENABLE | CW_ALARM_EN, 1'b0);
      queue_op(FUNC_WRITE, 2, REG_LOAD, 32'h0, 1'b0);
      repeat (24)
         queue_tick();
      queue_op(FUNC_WRITE, 2, REG_UPDATE, 32'h0, 1'b0);
      queue_op(FUNC_READ, 2, REG_LO, 32'h0, 1'b0);
      queue_op(FUNC_READ, 2, REG_CONFIG, 32'h0, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every transaction to be sent and every result to be taken
      do
         @(negedge clock);
      while (bus_ops.size() != 0 || req_valid || timer_rsps_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (!failed)
         $display("prescaled_alarm_timer_regs_top_tb: PASS");
      else
         $display("prescaled_alarm_timer_regs_top_tb: FAIL");
      $finish;
   end

endmodule
